// ===== hdl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared constants and types of the radix digit converter
// Widths of the value, the digit store and the divider control records.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int FIELD_W     = 31;
  localparam int DIGIT_W     = 31;
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(VALUE_BITS + 1);

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIGIT_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_stat_t;

endpackage

// ===== hdl/rdc_if.sv =====
// ----------------------------------------------------------------------------
// rdc_item_if / rdc_result_if: valid-ready channels of the converter
// Input word carries value and base; result word carries one digit and flags.
// ----------------------------------------------------------------------------
interface rdc_item_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::FIELD_W-1:0] value;
  logic [rdc_pkg::FIELD_W-1:0] base;

  modport source (output valid, output value, output base, input ready);
  modport sink (input valid, input value, input base, output ready);
endinterface

interface rdc_result_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::DIGIT_W-1:0] digit;
  logic                        last;
  logic                        empty_value;
  logic                        bad_base;

  modport source (output valid, output digit, output last, output empty_value,
                  output bad_base, input ready);
  modport sink (input valid, input digit, input last, input empty_value,
                input bad_base, output ready);
endinterface

// ===== hdl/rdc_divider.sv =====
// ----------------------------------------------------------------------------
// rdc_divider: bit-serial restoring divider
// One quotient bit per cycle; done pulses after VALUE_BITS steps.
// ----------------------------------------------------------------------------
module rdc_divider (
  input  logic              clk,
  input  logic              rst,
  input  rdc_pkg::div_req_t req,
  output rdc_pkg::div_stat_t stat
);

  logic [rdc_pkg::VALUE_BITS-1:0] quo;
  logic [rdc_pkg::DIGIT_W-1:0]    rem;
  logic [rdc_pkg::DIGIT_W-1:0]    dvs;
  logic [rdc_pkg::STEP_W-1:0]     cnt;
  logic                           busy;
  logic                           done;

  logic [rdc_pkg::DIGIT_W:0]      trial;
  logic [rdc_pkg::DIGIT_W+1:0]    diff;
  logic                           ge;

  assign trial = {rem, quo[rdc_pkg::VALUE_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign ge    = ~diff[rdc_pkg::DIGIT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rdc_pkg::STEP_W'(rdc_pkg::VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rdc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      quo <= {quo[rdc_pkg::VALUE_BITS-2:0], ge};
      rem <= ge ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
    end
  end

  assign stat.busy      = busy;
  assign stat.done      = done;
  assign stat.quotient  = quo;
  assign stat.remainder = rem;

endmodule

// ===== hdl/rdc_stack.sv =====
// ----------------------------------------------------------------------------
// rdc_stack: digit store of the converter
// One write port and one registered read port over a small memory.
// ----------------------------------------------------------------------------
module rdc_stack (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [rdc_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [rdc_pkg::DIGIT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [rdc_pkg::ADDR_W-1:0]  rd_addr,
  output logic [rdc_pkg::DIGIT_W-1:0] rd_data
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [rdc_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to radix digits, most significant first
// Sequence: the value is divided by the base until the quotient is zero, each
//   remainder pushed to the digit store; then each digit is read (S_READ) and
//   emitted (S_EMIT), waiting in S_EMIT while the output is held.
// Throughput: one input word at a time; a new word is taken only in S_IDLE.
// Zero value or base below 2: one flagged result, the next cycle.
// Reset: synchronous, clears the sequencer, divider, stack pointer and output.
// ----------------------------------------------------------------------------
module radix_digit_converter (
  input  logic          clk,
  input  logic          rst,
  rdc_item_if.sink      item,
  rdc_result_if.source  result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [rdc_pkg::CNT_W-1:0]   sp, sp_next;
  rdc_pkg::div_req_t           div_req;
  rdc_pkg::div_stat_t          div_stat;
  logic                        wr_en;
  logic                        rd_en;
  logic [rdc_pkg::CNT_W-1:0]   rd_ptr;
  logic [rdc_pkg::DIGIT_W-1:0] rd_data;

  logic                        out_valid, out_valid_next;
  logic [rdc_pkg::DIGIT_W-1:0] out_digit, out_digit_next;
  logic                        out_last, out_last_next;
  logic                        out_empty, out_empty_next;
  logic                        out_bad, out_bad_next;

  logic                        out_free;
  logic                        accept;
  logic [rdc_pkg::VALUE_BITS-1:0] value_in;
  logic [rdc_pkg::DIGIT_W-1:0]    base_in;
  logic [rdc_pkg::DIGIT_W-1:0]    base_reg;

  assign out_free   = ~out_valid | result.ready;
  assign item.ready = (state == S_IDLE) & out_free;
  assign accept     = item.valid & item.ready;
  assign value_in   = rdc_pkg::VALUE_BITS'(item.value);
  assign base_in    = rdc_pkg::DIGIT_W'(item.base);
  assign rd_ptr     = sp - 1'b1;

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    div_req.start    = 1'b0;
    div_req.dividend = value_in;
    div_req.divisor  = base_in;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    out_valid_next = out_valid & ~result.ready;
    out_digit_next = out_digit;
    out_last_next  = out_last;
    out_empty_next = out_empty;
    out_bad_next   = out_bad;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          sp_next = '0;
          if (base_in < rdc_pkg::DIGIT_W'(2)) begin
            out_valid_next = 1'b1;
            out_digit_next = '0;
            out_last_next  = 1'b1;
            out_empty_next = 1'b0;
            out_bad_next   = 1'b1;
          end else if (value_in == '0) begin
            out_valid_next = 1'b1;
            out_digit_next = '0;
            out_last_next  = 1'b1;
            out_empty_next = 1'b1;
            out_bad_next   = 1'b0;
          end else begin
            div_req.start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_req.dividend = div_stat.quotient;
        div_req.divisor  = base_reg;
        if (div_stat.done) begin
          // push the remainder, divide again until the quotient runs out
          wr_en   = 1'b1;
          sp_next = sp + 1'b1;
          if (div_stat.quotient == '0) begin
            state_next = S_READ;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        sp_next    = rd_ptr;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_digit_next = rd_data;
          out_last_next  = (sp == '0);
          out_empty_next = 1'b0;
          out_bad_next   = 1'b0;
          state_next     = (sp == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sp        <= sp_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_digit <= out_digit_next;
    out_last  <= out_last_next;
    out_empty <= out_empty_next;
    out_bad   <= out_bad_next;
  end

  // hold the base for every division of this word
  always_ff @(posedge clk) begin
    if (accept) begin
      base_reg <= base_in;
    end
  end

  rdc_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  rdc_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sp[rdc_pkg::ADDR_W-1:0]),
    .wr_data (div_stat.remainder),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[rdc_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign result.valid       = out_valid;
  assign result.digit       = out_digit;
  assign result.last        = out_last;
  assign result.empty_value = out_empty;
  assign result.bad_base    = out_bad;

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= rdc_pkg::CNT_W'(rdc_pkg::STACK_DEPTH))
    else $error("digit stack pointer beyond depth");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.bad_base || result.empty_value) |-> result.last)
    else $error("flagged result not marked last");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> sp < rdc_pkg::CNT_W'(rdc_pkg::STACK_DEPTH))
    else $error("push into a full digit stack");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for radix_digit_converter
// Drives value/base words through a table of directed cases and then random
// words, and predicts every digit word in SystemVerilog. Each accepted result
// word is checked field by field against the oldest pending digit. Both
// channels idle at random; the sender drains the block completely three times.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_WORDS = 310;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [rdc_pkg::FIELD_W-1:0] MAX_FIELD = {rdc_pkg::FIELD_W{1'b1}};

  typedef struct packed {
    logic [rdc_pkg::DIGIT_W-1:0] digit;
    logic                        last;
    logic                        empty_value;
    logic                        bad_base;
  } digit_rec_t;

  typedef struct {
    logic [rdc_pkg::FIELD_W-1:0] value;
    logic [rdc_pkg::FIELD_W-1:0] base;
    bit                          typed;
    digit_rec_t                  want;
  } stim_row_t;

  logic clk;
  logic rst;
  int   cycle_cnt = 0;
  int   fail_count = 0;
  int   words_sent = 0;
  int   digits_seen = 0;

  digit_rec_t pending_digits[$];
  stim_row_t  directed_rows[$];

  rdc_item_if   item_ch ();
  rdc_result_if result_ch ();

  radix_digit_converter u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** radix_digit_converter: FAILED **");
      $finish;
    end
  end

  function automatic void log_failure(input string what);
    if (fail_count < 10) $display("%s", what);
    fail_count++;
  endfunction

  // Divide repeatedly, then queue the remainders most significant first.
  function automatic void predict_digits(input logic [rdc_pkg::FIELD_W-1:0] v,
                                         input logic [rdc_pkg::FIELD_W-1:0] b);
    logic [rdc_pkg::VALUE_BITS-1:0] n;
    logic [rdc_pkg::DIGIT_W-1:0]    rems[64];
    int                             depth;
    digit_rec_t                     rec;
    n = rdc_pkg::VALUE_BITS'(v);
    depth = 0;
    if (b < 2) begin
      rec = '{digit: '0, last: 1'b1, empty_value: 1'b0, bad_base: 1'b1};
      pending_digits.push_back(rec);
    end else if (n == 0) begin
      rec = '{digit: '0, last: 1'b1, empty_value: 1'b1, bad_base: 1'b0};
      pending_digits.push_back(rec);
    end else begin
      while (n != 0 && depth < 64) begin
        rems[depth] = rdc_pkg::DIGIT_W'(n % b);
        n = n / b;
        depth++;
      end
      while (depth > 0) begin
        depth--;
        rec = '{digit: rems[depth], last: (depth == 0), empty_value: 1'b0,
                bad_base: 1'b0};
        pending_digits.push_back(rec);
      end
    end
  endfunction

  function automatic void add_row(input logic [rdc_pkg::FIELD_W-1:0] v,
                                  input logic [rdc_pkg::FIELD_W-1:0] b,
                                  input bit typed,
                                  input logic [rdc_pkg::DIGIT_W-1:0] d,
                                  input logic lst,
                                  input logic emp, input logic bad);
    stim_row_t row;
    row.value = v;
    row.base = b;
    row.typed = typed;
    row.want = '{digit: d, last: lst, empty_value: emp, bad_base: bad};
    directed_rows.push_back(row);
  endfunction

  // Hold valid across back-to-back words; lower it only when a gap is drawn.
  task automatic send_word(input logic [rdc_pkg::FIELD_W-1:0] v,
                           input logic [rdc_pkg::FIELD_W-1:0] b);
    int gap;
    gap = (((words_sent / 32) % 4) == 3) ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.base  <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  // Stimulus
  initial begin
    logic [rdc_pkg::FIELD_W-1:0] v;
    logic [rdc_pkg::FIELD_W-1:0] b;
    int                          pick;
    item_ch.valid = 1'b0;
    item_ch.value = '0;
    item_ch.base  = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    add_row('0,            '0,        1, '0,            1, 0, 1);
    add_row('0,            1,         1, '0,            1, 0, 1);
    add_row(MAX_FIELD,     '0,        1, '0,            1, 0, 1);
    add_row(MAX_FIELD,     1,         1, '0,            1, 0, 1);
    add_row('0,            2,         1, '0,            1, 1, 0);
    add_row('0,            MAX_FIELD, 1, '0,            1, 1, 0);
    add_row(1,             2,         1, 1,             1, 0, 0);
    add_row(1,             MAX_FIELD, 1, 1,             1, 0, 0);
    add_row(MAX_FIELD - 1, MAX_FIELD, 1, MAX_FIELD - 1, 1, 0, 0);
    add_row(MAX_FIELD,     MAX_FIELD, 0, '0, 0, 0, 0);
    add_row(MAX_FIELD,     2,         0, '0, 0, 0, 0);
    add_row(MAX_FIELD,     3,         0, '0, 0, 0, 0);
    add_row(31'h4000_0000, 2,         0, '0, 0, 0, 0);
    add_row(12345,         10,        0, '0, 0, 0, 0);
    add_row(255,           16,        0, '0, 0, 0, 0);
    add_row(256,           16,        0, '0, 0, 0, 0);
    add_row(2,             2,         0, '0, 0, 0, 0);
    add_row(31'h5555_5555, 2,         0, '0, 0, 0, 0);
    add_row(31'h2AAA_AAAA, 4,         0, '0, 0, 0, 0);
    add_row(100,           100,       0, '0, 0, 0, 0);
    add_row(MAX_FIELD,     31'h1_0000, 0, '0, 0, 0, 0);
    add_row(MAX_FIELD,     31'h4000_0000, 0, '0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) pending_digits.push_back(directed_rows[i].want);
      else predict_digits(directed_rows[i].value, directed_rows[i].base);
      send_word(directed_rows[i].value, directed_rows[i].base);
    end
    wait_drained();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick = int'($urandom_range(0, 99));
      v = rdc_pkg::FIELD_W'($urandom);
      if (pick < 4) begin
        b = rdc_pkg::FIELD_W'($urandom_range(0, 1));
      end else if (pick < 8) begin
        v = '0;
        b = rdc_pkg::FIELD_W'($urandom_range(2, MAX_FIELD));
      end else if (pick < 40) begin
        v = v >> $urandom_range(0, 30);
        b = rdc_pkg::FIELD_W'($urandom_range(2, 16));
      end else if (pick < 65) begin
        b = rdc_pkg::FIELD_W'($urandom_range(2, 1000));
      end else if (pick < 85) begin
        b = rdc_pkg::FIELD_W'($urandom);
      end else begin
        b = v >> $urandom_range(0, 2);
      end
      predict_digits(v, b);
      send_word(v, b);
      if (k == RANDOM_WORDS / 2) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_digits.size() == 0) begin
      $display("** radix_digit_converter: PASSED **");
    end else begin
      $display("** radix_digit_converter: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls per word, with stretches of steady ready
  initial begin
    int         stall;
    digit_rec_t got;
    digit_rec_t want;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (((digits_seen / 64) % 3) == 2) ? 0 : int'($urandom_range(0, 6));
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      digits_seen++;
      got = '{digit: result_ch.digit, last: result_ch.last,
              empty_value: result_ch.empty_value, bad_base: result_ch.bad_base};
      if (pending_digits.size() == 0) begin
        log_failure($sformatf("unexpected result word: digit %0h last %0b empty %0b bad %0b",
                              got.digit, got.last, got.empty_value, got.bad_base));
      end else begin
        want = pending_digits.pop_front();
        if (got.digit !== want.digit || got.last !== want.last ||
            got.empty_value !== want.empty_value || got.bad_base !== want.bad_base) begin
          log_failure($sformatf(
            "mismatch word %0d: digit %0h/%0h last %0b/%0b empty %0b/%0b bad %0b/%0b (exp/got)",
            digits_seen, want.digit, got.digit, want.last, got.last,
            want.empty_value, got.empty_value, want.bad_base, got.bad_base));
        end
      end
    end
  end

endmodule

// ===== radix_digit_converter.f =====
hdl/rdc_pkg.sv
hdl/rdc_if.sv
hdl/rdc_divider.sv
hdl/rdc_stack.sv
hdl/radix_digit_converter.sv
dv/testbench.sv
